// ===== rtl/dlmt_pkg.sv =====
// shared types and constants of the dfa longest match tokenizer
package dlmt_pkg;

    localparam int DFA_STATES      = 256;
    localparam int SLOTS_PER_STATE = 16;
    localparam int BUF_DEPTH       = 32;
    localparam int STATE_W = $clog2(DFA_STATES);
    localparam int SLOT_W  = $clog2(SLOTS_PER_STATE);
    localparam int TBL_W   = STATE_W + SLOT_W;
    localparam int PTR_W   = $clog2(BUF_DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam logic [30:0] FLUSH_TOKEN = 31'h7fffffff;

    localparam logic [1:0] CMD_TRANS = 2'd0;
    localparam logic [1:0] CMD_INFO  = 2'd1;
    localparam logic [1:0] CMD_FEED  = 2'd2;

    localparam logic [1:0] EV_ACCEPT   = 2'd0;
    localparam logic [1:0] EV_REJECT   = 2'd1;
    localparam logic [1:0] EV_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  state_index;
        logic [3:0]  slot_index;
        logic [30:0] range_first;
        logic [31:0] range_end;
        logic [7:0]  target_state;
        logic [4:0]  transition_count;
        logic [7:0]  accept_tag;
        logic [30:0] token;
    } t_in_word;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [5:0] match_length;
        logic [7:0] match_tag;
        logic [7:0] match_state;
        logic       last;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SCAN_RD, OP_LK_INIT, OP_BS_RD, OP_BS_STEP,
        OP_INFO_RD, OP_TRANS, OP_RESOLVE, OP_FINISH
    } t_dp_op;

    typedef struct packed {
        logic        in_cmd_feed;
        logic        in_flush;
        logic        buf_full;
        logic        buf_empty;
        logic        off_lt_count;
        logic        cnt_zero;
        logic        hi_ge_lo;
        logic        hit;
        logic        pend_valid;
        logic        emit_ok;
        logic        out_free;
        logic [CNT_W-1:0] count;
    } t_dp_status;

endpackage

// ===== rtl/dfa_longest_match_tokenizer.sv =====
// top level of the dfa longest match tokenizer
// Table writes (cmd 0 and 1) and unused commands end in the load step. For a fed token the
// scan step reads the state info and buffer slot, the lookup step takes the token and sets
// the bounds, and each binary search probe (1 to 5 over up to sixteen sorted slots, one
// table memory port) reads and compares a slot. A hit reads the target's info, then the
// transition step runs and the scan step checks for the end of the buffer before finishing.
// A failed search, or a state with no exits after its lookup step, resolves and the
// buffered tokens are rescanned. An overflow goes from the load step to the finish step;
// a flush of an empty buffer passes the scan check first. Results pass through a pending
// register and an output register; a step that emits waits while both are full, and a new
// word is taken once the last result of the previous word is in the output register.
module dfa_longest_match_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dlmt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dlmt_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data
);
    import dlmt_pkg::*;

    t_dp_op     op;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    dlmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_op       (op)
    );

    dlmt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_status    (status)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= CNT_W'(BUF_DEPTH))
        else $error("buffer count beyond depth");

    a_overflow_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind == EV_OVERFLOW
        |-> o_out_word.match_length == '0 && o_out_word.last)
        else $error("malformed overflow result");

    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.event_kind != EV_OVERFLOW
        |-> o_out_word.match_length != '0)
        else $error("empty match result");

endmodule

// ===== rtl/dlmt_ctrl.sv =====
// sequencing state machine of the tokenizer
module dlmt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dlmt_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output dlmt_pkg::t_dp_op    o_op
);
    import dlmt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_LK, S_BSR, S_BSC, S_INFO, S_TRANS, S_RESOLVE, S_FINISH
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op = OP_LOAD;
                    if (i_status.in_cmd_feed) begin
                        if (i_status.in_flush) begin
                            n_state = i_status.buf_empty ? S_SCAN : S_RESOLVE;
                        end else if (i_status.buf_full) begin
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_status.off_lt_count) begin
                    o_op    = OP_SCAN_RD;
                    n_state = S_LK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_LK: begin
                o_op    = OP_LK_INIT;
                n_state = i_status.cnt_zero ? S_RESOLVE : S_BSR;
            end
            S_BSR: begin
                if (i_status.hi_ge_lo) begin
                    o_op    = OP_BS_RD;
                    n_state = S_BSC;
                end else begin
                    n_state = S_RESOLVE;
                end
            end
            S_BSC: begin
                o_op    = OP_BS_STEP;
                n_state = i_status.hit ? S_INFO : S_BSR;
            end
            S_INFO: begin
                o_op    = OP_INFO_RD;
                n_state = S_TRANS;
            end
            S_TRANS: begin
                if (i_status.emit_ok) begin
                    o_op    = OP_TRANS;
                    n_state = S_SCAN;
                end
            end
            S_RESOLVE: begin
                if (i_status.emit_ok) begin
                    o_op    = OP_RESOLVE;
                    n_state = S_SCAN;
                end
            end
            S_FINISH: begin
                if (!i_status.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_op    = OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dlmt_datapath.sv =====
// tables, backtrack buffer, search registers and result registers
module dlmt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dlmt_pkg::t_dp_op     i_op,
    input  dlmt_pkg::t_in_word   i_in_word,
    input  logic                 i_cfg_valid,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output dlmt_pkg::t_out_word  o_out_word,
    output dlmt_pkg::t_dp_status o_status
);
    import dlmt_pkg::*;

    logic [70:0]  r_tbl_mem [DFA_STATES*SLOTS_PER_STATE];
    logic [12:0]  r_info_mem [DFA_STATES];
    logic [30:0]  r_buf_mem [BUF_DEPTH];
    logic [70:0]  r_tbl_q;
    logic [12:0]  r_info_q;
    logic [30:0]  r_buf_q;

    logic [7:0]       r_start, r_cur_s, r_ns, r_acc_state, r_acc_tag;
    logic [PTR_W-1:0] r_head, r_acc_pos;
    logic [CNT_W-1:0] r_count, r_off;
    logic             r_acc_valid;
    logic [30:0]      r_tok;
    logic [4:0]       r_lo;
    logic [5:0]       r_hi;
    logic             r_pend_v, r_out_v;
    t_out_word        r_pend, r_out;

    logic [4:0]       sat_cnt, mid5;
    logic [SLOT_W-1:0] mid;
    logic             first_gt, end_le;
    logic [CNT_W-1:0] off1, res_len;
    logic [PTR_W-1:0] diff;
    logic             out_free, emit_ok;
    t_out_word        emit_word;
    t_out_word        fin_word;
    logic             do_emit;

    assign sat_cnt  = (r_info_q[4:0] > 5'(SLOTS_PER_STATE)) ? 5'(SLOTS_PER_STATE)
                                                           : r_info_q[4:0];
    assign mid5     = 5'(({1'b0, r_lo} + r_hi) >> 1);
    assign mid      = mid5[SLOT_W-1:0];
    assign first_gt = r_tbl_q[30:0] > r_tok;
    assign end_le   = r_tbl_q[62:31] <= {1'b0, r_tok};
    assign off1     = r_off + 1'b1;
    assign diff     = r_acc_pos - r_head;
    assign res_len  = (diff == '0 || {1'b0, diff} > r_count) ? r_count : {1'b0, diff};
    assign out_free = !r_out_v || i_out_ready;
    assign emit_ok  = !r_pend_v || out_free;

    assign o_status.in_cmd_feed  = (i_in_word.cmd == CMD_FEED);
    assign o_status.in_flush     = (i_in_word.token == FLUSH_TOKEN);
    assign o_status.buf_full     = (r_count == CNT_W'(BUF_DEPTH));
    assign o_status.buf_empty    = (r_count == '0);
    assign o_status.off_lt_count = (r_off < r_count);
    assign o_status.cnt_zero     = (sat_cnt == '0);
    assign o_status.hi_ge_lo     = $signed(r_hi) >= $signed({1'b0, r_lo});
    assign o_status.hit          = !first_gt && !end_le;
    assign o_status.pend_valid   = r_pend_v;
    assign o_status.emit_ok      = emit_ok;
    assign o_status.out_free     = out_free;
    assign o_status.count        = r_count;

    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    always_comb begin
        fin_word      = r_pend;
        fin_word.last = 1'b1;
    end

    always_comb begin
        emit_word = '0;
        do_emit   = 1'b0;
        if (i_op == OP_TRANS && r_info_q[12:5] != '0 && r_info_q[4:0] == '0) begin
            do_emit                = 1'b1;
            emit_word.event_kind   = EV_ACCEPT;
            emit_word.match_length = off1;
            emit_word.match_tag    = r_info_q[12:5];
            emit_word.match_state  = r_ns;
        end else if (i_op == OP_RESOLVE) begin
            do_emit = 1'b1;
            if (r_acc_valid) begin
                emit_word.event_kind   = EV_ACCEPT;
                emit_word.match_length = res_len;
                emit_word.match_tag    = r_acc_tag;
                emit_word.match_state  = r_acc_state;
            end else begin
                emit_word.event_kind   = EV_REJECT;
                emit_word.match_length = 6'd1;
            end
        end else if (i_op == OP_LOAD && i_in_word.cmd == CMD_FEED
                     && i_in_word.token != FLUSH_TOKEN
                     && r_count == CNT_W'(BUF_DEPTH)) begin
            do_emit              = 1'b1;
            emit_word.event_kind = EV_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD && i_in_word.cmd == CMD_TRANS) begin
            r_tbl_mem[{i_in_word.state_index, i_in_word.slot_index}] <=
                {i_in_word.target_state, i_in_word.range_end, i_in_word.range_first};
        end
        r_tbl_q <= r_tbl_mem[{r_cur_s, mid}];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD && i_in_word.cmd == CMD_INFO) begin
            r_info_mem[i_in_word.state_index] <=
                {i_in_word.accept_tag, i_in_word.transition_count};
        end
        if (i_op == OP_SCAN_RD) begin
            r_info_q <= r_info_mem[r_cur_s];
        end else if (i_op == OP_INFO_RD) begin
            r_info_q <= r_info_mem[r_ns];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LOAD && i_in_word.cmd == CMD_FEED
            && i_in_word.token != FLUSH_TOKEN && r_count != CNT_W'(BUF_DEPTH)) begin
            r_buf_mem[r_head + r_count[PTR_W-1:0]] <= i_in_word.token;
        end
        r_buf_q <= r_buf_mem[r_head + r_off[PTR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_LK_INIT) begin
            r_tok <= r_buf_q;
            r_lo  <= '0;
            r_hi  <= {1'b0, sat_cnt} - 6'd1;
        end
        if (i_op == OP_BS_STEP) begin
            if (first_gt) begin
                r_hi <= {1'b0, mid5} - 6'd1;
            end else if (end_le) begin
                r_lo <= mid5 + 5'd1;
            end else begin
                r_ns <= r_tbl_q[70:63];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_cur_s     <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_off       <= '0;
            r_acc_pos   <= '0;
            r_acc_valid <= 1'b0;
            r_acc_state <= '0;
            r_acc_tag   <= '0;
            r_pend_v    <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (do_emit && r_pend_v) begin
                r_out   <= r_pend;
                r_out_v <= 1'b1;
            end else if (i_op == OP_FINISH) begin
                r_out   <= fin_word;
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (do_emit) begin
                r_pend   <= emit_word;
                r_pend_v <= 1'b1;
            end else if (i_op == OP_FINISH) begin
                r_pend_v <= 1'b0;
            end
            case (i_op)
                OP_LOAD: begin
                    if (i_in_word.cmd == CMD_INFO && i_in_word.state_index == r_acc_state) begin
                        r_acc_tag <= i_in_word.accept_tag;
                    end
                    if (i_in_word.cmd == CMD_FEED) begin
                        if (i_in_word.token == FLUSH_TOKEN) begin
                            if (r_count == '0) begin
                                r_acc_valid <= 1'b0;
                                r_cur_s     <= r_start;
                                r_off       <= '0;
                            end
                        end else if (r_count != CNT_W'(BUF_DEPTH)) begin
                            r_off   <= r_count;
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                OP_TRANS: begin
                    if (r_info_q[12:5] != '0 && r_info_q[4:0] == '0) begin
                        r_head      <= r_head + off1[PTR_W-1:0];
                        r_count     <= r_count - off1;
                        r_acc_valid <= 1'b0;
                        r_cur_s     <= r_start;
                        r_off       <= '0;
                    end else begin
                        r_cur_s <= r_ns;
                        r_off   <= off1;
                        if (r_info_q[12:5] != '0) begin
                            r_acc_valid <= 1'b1;
                            r_acc_pos   <= r_head + off1[PTR_W-1:0];
                            r_acc_state <= r_ns;
                            r_acc_tag   <= r_info_q[12:5];
                        end
                    end
                end
                OP_RESOLVE: begin
                    if (r_acc_valid) begin
                        r_head  <= r_head + res_len[PTR_W-1:0];
                        r_count <= r_count - res_len;
                    end else begin
                        r_head  <= r_head + 1'b1;
                        r_count <= r_count - 1'b1;
                    end
                    r_acc_valid <= 1'b0;
                    r_cur_s     <= r_start;
                    r_off       <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/dfa_longest_match_tokenizer_tb.sv =====
// testbench of the dfa longest match tokenizer: directed table, random dfa phases, scoreboard
`timescale 1ns / 1ps

module dfa_longest_match_tokenizer_tb;
    import dlmt_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int SETTLE    = 600;
    localparam int WD_LIMIT  = 4000;
    localparam int HOLD_OFF  = 400;
    localparam int TBL_DEPTH = DFA_STATES * SLOTS_PER_STATE;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    dfa_longest_match_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the dfa tables and the backtrack buffer
    logic [30:0] slot_first [TBL_DEPTH];
    logic [31:0] slot_end   [TBL_DEPTH];
    logic [7:0]  slot_next  [TBL_DEPTH];
    logic [4:0]  info_count [DFA_STATES];
    logic [7:0]  info_tag   [DFA_STATES];
    logic [30:0] tok_buf    [BUF_DEPTH];
    int          cur_st, buf_head, buf_fill, mark_pos, mark_st, start_st;
    bit          mark_ok;

    t_out_word step_events[$];
    t_out_word match_events[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        burst = 0;
    int        pool [8] = '{0, 1, 2, 3, 4, 5, 6, 255};
    t_row      dir_tab[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int tag_of(int s);
        return int'(info_tag[s]);
    endfunction

    function automatic int count_of(int s);
        int c;
        c = int'(info_count[s]);
        return (c > SLOTS_PER_STATE) ? SLOTS_PER_STATE : c;
    endfunction

    function automatic int slot_lookup(int s, logic [30:0] tok);
        int lo, hi, mid, idx;
        lo = 0;
        hi = count_of(s) - 1;
        while (hi >= lo) begin
            mid = (lo + hi) >>> 1;
            idx = s * SLOTS_PER_STATE + mid;
            if (slot_first[idx] > tok) hi = mid - 1;
            else if (slot_end[idx] <= {1'b0, tok}) lo = mid + 1;
            else return int'(slot_next[idx]);
        end
        return -1;
    endfunction

    task automatic add_event(logic [1:0] kind, int len, int tg, int st);
        t_out_word e;
        if (step_events.size() >= 34) return;
        e.event_kind   = kind;
        e.match_length = len[5:0];
        e.match_tag    = tg[7:0];
        e.match_state  = st[7:0];
        e.last         = 1'b0;
        step_events.push_back(e);
    endtask

    task automatic drop_front(int n);
        if (n > buf_fill) n = buf_fill;
        buf_head = (buf_head + n) % BUF_DEPTH;
        buf_fill -= n;
    endtask

    task automatic settle_dead_end();
        int len;
        if (mark_ok) begin
            len = (mark_pos >= buf_head) ? mark_pos - buf_head : mark_pos + BUF_DEPTH - buf_head;
            if (len == 0 || len > buf_fill) len = buf_fill;
            add_event(EV_ACCEPT, len, tag_of(mark_st), mark_st);
            drop_front(len);
        end else begin
            add_event(EV_REJECT, 1, 0, 0);
            drop_front(1);
        end
        mark_ok = 0;
    endtask

    task automatic munch(int off, int s);
        int ns;
        while (off < buf_fill) begin
            ns = slot_lookup(s, tok_buf[(buf_head + off) % BUF_DEPTH]);
            if (ns < 0) begin
                settle_dead_end();
                s = start_st;
                off = 0;
            end else begin
                s = ns;
                off++;
                if (tag_of(s) != 0) begin
                    if (count_of(s) == 0) begin
                        add_event(EV_ACCEPT, off, tag_of(s), s);
                        drop_front(off);
                        mark_ok = 0;
                        s = start_st;
                        off = 0;
                    end else begin
                        mark_ok = 1;
                        mark_pos = (buf_head + off) % BUF_DEPTH;
                        mark_st = s;
                    end
                end
            end
        end
        cur_st = s;
    endtask

    task automatic predict(t_in_word w);
        int idx;
        step_events.delete();
        case (w.cmd)
            CMD_TRANS: begin
                idx = int'(w.state_index) * SLOTS_PER_STATE + int'(w.slot_index);
                slot_first[idx] = w.range_first;
                slot_end[idx]   = w.range_end;
                slot_next[idx]  = w.target_state;
            end
            CMD_INFO: begin
                info_count[w.state_index] = w.transition_count;
                info_tag[w.state_index]   = w.accept_tag;
            end
            CMD_FEED: begin
                if (w.token == FLUSH_TOKEN) begin
                    if (buf_fill > 0) settle_dead_end();
                    mark_ok = 0;
                    munch(0, start_st);
                end else if (buf_fill >= BUF_DEPTH) begin
                    add_event(EV_OVERFLOW, 0, 0, 0);
                end else begin
                    tok_buf[(buf_head + buf_fill) % BUF_DEPTH] = w.token;
                    buf_fill++;
                    munch(buf_fill - 1, cur_st);
                end
                if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
                foreach (step_events[i]) match_events.push_back(step_events[i]);
            end
            default: ;
        endcase
    endtask

    function automatic t_in_word noise_word();
        logic [159:0] r;
        r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return t_in_word'(r[$bits(t_in_word)-1:0]);
    endfunction

    function automatic t_in_word trans_word(int s, int sl, logic [30:0] f, logic [31:0] e, int t);
        t_in_word w;
        w = noise_word();
        w.cmd          = CMD_TRANS;
        w.state_index  = s[7:0];
        w.slot_index   = sl[3:0];
        w.range_first  = f;
        w.range_end    = e;
        w.target_state = t[7:0];
        return w;
    endfunction

    function automatic t_in_word info_word(int s, int c, int tg);
        t_in_word w;
        w = noise_word();
        w.cmd              = CMD_INFO;
        w.state_index      = s[7:0];
        w.transition_count = c[4:0];
        w.accept_tag       = tg[7:0];
        return w;
    endfunction

    function automatic t_in_word feed_word(logic [30:0] tok);
        t_in_word w;
        w = noise_word();
        w.cmd   = CMD_FEED;
        w.token = tok;
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict(w);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (match_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_start(int v);
        i_cfg_data  <= v[7:0];
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        start_st = v;
    endtask

    task automatic load_state(int s, bit wide);
        int n, c, cur;
        logic [30:0] f [16];
        logic [31:0] e [16];
        bit flip;
        n = wide ? 16 : $urandom_range(0, 4);
        c = wide ? $urandom_range(16, 31) : n;
        cur = $urandom_range(0, 2);
        flip = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++) begin
            f[i] = 31'(cur);
            e[i] = 32'(cur + $urandom_range(1, 4));
            if (i == n - 1 && $urandom_range(0, 2) == 0) e[i] = 32'h8000_0000;
            cur = int'(e[i]) + $urandom_range(0, 1);
        end
        for (int i = 0; i < n; i++) begin
            send_word(trans_word(s, i, f[flip ? n - 1 - i : i], e[flip ? n - 1 - i : i],
                                 pool[$urandom_range(0, 7)]));
        end
        send_word(info_word(s, c, ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 255)));
    endtask

    task automatic random_item();
        int r;
        t_in_word w;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            send_word(feed_word(FLUSH_TOKEN));
        end else if (r == 2) begin
            send_word(feed_word(31'($urandom())));
        end else if (r == 3) begin
            w = noise_word();
            w.state_index = 8'($urandom_range(7, 254));
            if (w.cmd == CMD_FEED) w.cmd = CMD_NOP;
            send_word(w);
        end else begin
            send_word(feed_word(31'($urandom_range(0, 24))));
        end
    endtask

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (match_events.size() == 0) begin
                $display("%0t: unexpected word, expected none got %h", $time, o_out_word);
                errors++;
            end else begin
                e = match_events.pop_front();
                check_field("event_kind", e.event_kind, o_out_word.event_kind);
                check_field("match_length", e.match_length, o_out_word.match_length);
                check_field("match_tag", e.match_tag, o_out_word.match_tag);
                check_field("match_state", e.match_state, o_out_word.match_state);
                check_field("last", e.last, o_out_word.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WD_LIMIT) begin
            $display("dfa_longest_match_tokenizer test failed");
            $finish;
        end
    end

    // receiver with one long hold-off to back the block up
    initial begin
        int stall;
        int got;
        bit held;
        got = 0;
        held = 0;
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = burst ? 0 : $urandom_range(0, 8);
            if (!held && got == 15) begin
                stall = HOLD_OFF;
                held = 1;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got++;
        end
    end

    initial begin
        int starts [2] = '{255, 3};
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        cur_st = 0; buf_head = 0; buf_fill = 0; mark_pos = 0; mark_st = 0;
        start_st = 0; mark_ok = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir_tab.push_back('{trans_word(0, 0, 31'd0, 32'd10, 1), 0, '0});
        dir_tab.push_back('{trans_word(0, 1, 31'd10, 32'd20, 2), 0, '0});
        dir_tab.push_back('{info_word(0, 2, 0), 0, '0});
        dir_tab.push_back('{trans_word(1, 0, 31'd0, 32'd10, 1), 0, '0});
        dir_tab.push_back('{info_word(1, 1, 5), 0, '0});
        dir_tab.push_back('{info_word(2, 0, 7), 0, '0});
        dir_tab.push_back('{feed_word(31'd15), 1, '{EV_ACCEPT, 6'd1, 8'd7, 8'd2, 1'b1}});
        dir_tab.push_back('{feed_word(31'd3), 0, '0});
        dir_tab.push_back('{feed_word(31'd4), 0, '0});
        dir_tab.push_back('{feed_word(31'd50), 0, '0});
        dir_tab.push_back('{feed_word(31'd50), 1, '{EV_REJECT, 6'd1, 8'd0, 8'd0, 1'b1}});
        dir_tab.push_back('{feed_word(31'd2), 0, '0});
        dir_tab.push_back('{feed_word(FLUSH_TOKEN), 1, '{EV_ACCEPT, 6'd1, 8'd5, 8'd1, 1'b1}});
        dir_tab.push_back('{feed_word(FLUSH_TOKEN), 0, '0});
        dir_tab.push_back('{feed_word(31'd0), 0, '0});
        dir_tab.push_back('{feed_word(31'h7ffffffe), 0, '0});
        dir_tab.push_back('{info_word(170, 31, 255), 0, '0});
        dir_tab.push_back('{trans_word(170, 15, 31'h7fffffff, 32'hffffffff, 255), 0, '0});
        dir_tab.push_back('{feed_word(31'd12), 1, '{EV_ACCEPT, 6'd1, 8'd7, 8'd2, 1'b1}});

        write_start(0);
        foreach (dir_tab[i]) begin
            t_in_word w;
            w = dir_tab[i].w;
            if (i == 16) w.cmd = CMD_NOP;
            send_word(w);
            if (dir_tab[i].typed) match_events[match_events.size() - 1] = dir_tab[i].res;
        end

        for (int ph = 0; ph < 2; ph++) begin
            wait_idle();
            burst = (ph == 1);
            write_start(starts[ph]);
            foreach (pool[k]) load_state(pool[k], (ph == 0 && k == 3));
            for (int n = 0; n < 20; n++) random_item();
        end

        // self loop on the start state fills the buffer past its depth
        wait_idle();
        burst = 0;
        write_start(255);
        send_word(trans_word(255, 0, 31'd0, 32'h8000_0000, 255));
        send_word(info_word(255, 1, 3));
        send_word(feed_word(FLUSH_TOKEN));
        for (int n = 0; n < 36; n++) send_word(feed_word(31'($urandom_range(0, 'h7ffffffe))));
        send_word(feed_word(FLUSH_TOKEN));
        send_word(feed_word(31'd1));
        send_word(feed_word(FLUSH_TOKEN));

        wait_idle();
        if (errors == 0) begin
            $display("dfa_longest_match_tokenizer test passed");
        end else begin
            $display("dfa_longest_match_tokenizer test failed");
        end
        $finish;
    end

endmodule
